// ----- rtl/core/rmq_pkg.sv -----
// Shared types and constants for the rotation-matrix-to-quaternion core.
// Used by rmq_front, rmq_queue, rmq_back and the top level; no dependencies.
package rmq_pkg;

    localparam int Q_W    = 16;  // Q2.14 field width
    localparam int RAD_W  = 18;  // radicand, Q.14, always 16384..114687
    localparam int RAD_SH = 30;  // radicand is scaled by 2^30 before the root
    localparam int NM_W   = 17;  // magnitude of an off-diagonal sum/difference
    localparam int R1_W   = 24;  // first root, s/2 in Q.22
    localparam int C_W    = 25;  // component magnitude, Q.22 scaled by 2
    localparam int DV1_W  = NM_W + RAD_SH;
    localparam int L2_W   = 52;  // squared length, padded to an even width
    localparam int L_W    = L2_W / 2;
    localparam int NRM_SH = 14;
    localparam int QN_W   = 15;  // normalized magnitude, at most 16384
    localparam int DV2_W  = 1 + C_W + NRM_SH;
    localparam int ONE_Q14 = 16384;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    typedef struct packed {
        logic signed [Q_W-1:0] right_x;
        logic signed [Q_W-1:0] right_y;
        logic signed [Q_W-1:0] right_z;
        logic signed [Q_W-1:0] up_x;
        logic signed [Q_W-1:0] up_y;
        logic signed [Q_W-1:0] up_z;
        logic signed [Q_W-1:0] fwd_x;
        logic signed [Q_W-1:0] fwd_y;
        logic signed [Q_W-1:0] fwd_z;
    } t_in_item;

    typedef struct packed {
        logic signed [Q_W-1:0] quat_x;
        logic signed [Q_W-1:0] quat_y;
        logic signed [Q_W-1:0] quat_z;
        logic signed [Q_W-1:0] quat_w;
        logic                  degenerate;
    } t_out_item;

    // classified item: radicand, three off-diagonal magnitudes and signs
    typedef struct packed {
        logic [RAD_W-1:0]        rad;
        logic [2:0][NM_W-1:0]    nm;
        logic [2:0]              ns;
        t_branch                 sel;
    } t_cls;

    typedef struct packed {
        logic [R1_W+1:0]         rem;
        logic [R1_W-1:0]         root;
        logic [RAD_W-1:0]        rad;
        logic [2:0][NM_W-1:0]    nm;
        logic [2:0]              ns;
        t_branch                 sel;
    } t_s1;

    typedef struct packed {
        logic [2:0][DV1_W-1:0]   rem;
        logic [2:0][C_W-1:0]     q;
        logic [R1_W-1:0]         r;
        logic [2:0]              ns;
        t_branch                 sel;
    } t_d1;

    typedef struct packed {
        logic [3:0][C_W-1:0]     c;
        logic [3:0]              cs;
        logic [3:0][2*C_W-1:0]   sq;
    } t_as;

    typedef struct packed {
        logic [3:0][C_W-1:0]     c;
        logic [3:0]              cs;
        logic [L2_W-1:0]         len2;
    } t_sm;

    typedef struct packed {
        logic [L_W+1:0]          rem;
        logic [L_W-1:0]          root;
        logic [L2_W-1:0]         len2;
        logic [3:0][C_W-1:0]     c;
        logic [3:0]              cs;
    } t_s2;

    typedef struct packed {
        logic [3:0][DV2_W-1:0]   rem;
        logic [3:0][QN_W-1:0]    q;
        logic [L_W-1:0]          len;
        logic [3:0]              cs;
    } t_d2;

endpackage

// ----- rtl/core/rmq_front.sv -----
// Front end: takes a matrix, picks the Shepperd branch, forms the radicand
// and the off-diagonal terms, holds them in one register. Depends on rmq_pkg.
module rmq_front
    import rmq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_valid,
    output t_cls     o_cls,
    input  logic     i_q_full
);

    logic  r_fv;
    t_cls  r_cls;
    t_cls  n_cls;
    logic  w_adv;

    logic signed [19:0]     w_dsum;
    logic signed [19:0]     w_rad;
    logic signed [NM_W-1:0] w_n [3];

    assign w_adv   = !r_fv || !i_q_full;
    assign o_full  = !w_adv;
    assign o_valid = r_fv;
    assign o_cls   = r_cls;

    assign w_dsum = 20'(i_item.right_x) + 20'(i_item.up_y) + 20'(i_item.fwd_z);

    always_comb begin
        n_cls = '0;
        if (w_dsum > 0) begin
            n_cls.sel = BR_TRACE;
            w_rad  = 20'(ONE_Q14) + w_dsum;
            w_n[0] = NM_W'(i_item.up_z) - NM_W'(i_item.fwd_y);
            w_n[1] = NM_W'(i_item.fwd_x) - NM_W'(i_item.right_z);
            w_n[2] = NM_W'(i_item.right_y) - NM_W'(i_item.up_x);
        end else if (i_item.right_x > i_item.up_y && i_item.right_x > i_item.fwd_z) begin
            n_cls.sel = BR_X;
            w_rad  = 20'(ONE_Q14) + 20'(i_item.right_x) - 20'(i_item.up_y)
                   - 20'(i_item.fwd_z);
            w_n[0] = NM_W'(i_item.up_x) + NM_W'(i_item.right_y);
            w_n[1] = NM_W'(i_item.fwd_x) + NM_W'(i_item.right_z);
            w_n[2] = NM_W'(i_item.up_z) - NM_W'(i_item.fwd_y);
        end else if (i_item.up_y > i_item.fwd_z) begin
            n_cls.sel = BR_Y;
            w_rad  = 20'(ONE_Q14) + 20'(i_item.up_y) - 20'(i_item.right_x)
                   - 20'(i_item.fwd_z);
            w_n[0] = NM_W'(i_item.right_y) + NM_W'(i_item.up_x);
            w_n[1] = NM_W'(i_item.fwd_y) + NM_W'(i_item.up_z);
            w_n[2] = NM_W'(i_item.fwd_x) - NM_W'(i_item.right_z);
        end else begin
            n_cls.sel = BR_Z;
            w_rad  = 20'(ONE_Q14) + 20'(i_item.fwd_z) - 20'(i_item.right_x)
                   - 20'(i_item.up_y);
            w_n[0] = NM_W'(i_item.fwd_x) + NM_W'(i_item.right_z);
            w_n[1] = NM_W'(i_item.fwd_y) + NM_W'(i_item.up_z);
            w_n[2] = NM_W'(i_item.right_y) - NM_W'(i_item.up_x);
        end
        // radicand never drops below 16384, so the low bits carry it
        n_cls.rad = w_rad[RAD_W-1:0];
        for (int i = 0; i < 3; i++) begin
            n_cls.ns[i] = w_n[i][NM_W-1];
            n_cls.nm[i] = w_n[i][NM_W-1] ? NM_W'(-w_n[i]) : NM_W'(w_n[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_push) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ----- rtl/core/rmq_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on rmq_pkg for the entry type.
module rmq_queue
    import rmq_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cls o_data,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/rmq_back.sv -----
// Back end: pipelined root, off-diagonal divides, length root and normalizing
// divides, one bit per stage; the whole pipe stalls on i_en. Depends on rmq_pkg.
module rmq_back
    import rmq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_cls      i_cls,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int LAT = R1_W + C_W + 2 + L_W + QN_W + 1;

    logic [LAT-1:0] r_vld;
    t_s1       r_s1 [R1_W];
    t_d1       r_d1 [C_W];
    t_as       r_as;
    t_sm       r_sm;
    t_s2       r_s2 [L_W];
    t_d2       r_d2 [QN_W];
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_item  = r_out;

    // first root: r = floor(sqrt(rad * 2^30))
    t_s1 w_s1_in;
    always_comb begin
        w_s1_in      = '0;
        w_s1_in.rad  = i_cls.rad;
        w_s1_in.nm   = i_cls.nm;
        w_s1_in.ns   = i_cls.ns;
        w_s1_in.sel  = i_cls.sel;
    end

    for (genvar j = 0; j < R1_W; j++) begin : g_s1
        t_s1 w_p;
        t_s1 n_s;
        if (j == 0) begin : g_first
            assign w_p = w_s1_in;
        end else begin : g_next
            assign w_p = r_s1[j-1];
        end
        always_comb begin
            logic [2*R1_W-1:0] rv;
            logic [R1_W+3:0]   sh;
            logic [R1_W+3:0]   tr;
            n_s = w_p;
            rv  = {w_p.rad, {RAD_SH{1'b0}}};
            sh  = {w_p.rem, rv[2*(R1_W-1-j)+1 -: 2]};
            tr  = {2'b00, w_p.root, 2'b01};
            if (sh >= tr) begin
                n_s.rem  = (R1_W+2)'(sh - tr);
                n_s.root = {w_p.root[R1_W-2:0], 1'b1};
            end else begin
                n_s.rem  = sh[R1_W+1:0];
                n_s.root = {w_p.root[R1_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s1[j] <= n_s;
            end
        end
    end

    // off-diagonal terms: |n| * 2^30 / r
    t_d1 w_d1_in;
    always_comb begin
        w_d1_in     = '0;
        w_d1_in.r   = r_s1[R1_W-1].root;
        w_d1_in.ns  = r_s1[R1_W-1].ns;
        w_d1_in.sel = r_s1[R1_W-1].sel;
        for (int i = 0; i < 3; i++) begin
            w_d1_in.rem[i] = {r_s1[R1_W-1].nm[i], {RAD_SH{1'b0}}};
        end
    end

    for (genvar j = 0; j < C_W; j++) begin : g_d1
        t_d1 w_p;
        t_d1 n_d;
        if (j == 0) begin : g_first
            assign w_p = w_d1_in;
        end else begin : g_next
            assign w_p = r_d1[j-1];
        end
        always_comb begin
            logic [DV1_W:0] dsh;
            n_d = w_p;
            dsh = (DV1_W+1)'(w_p.r) << (C_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, w_p.rem[i]} >= dsh) begin
                    n_d.rem[i] = DV1_W'({1'b0, w_p.rem[i]} - dsh);
                    n_d.q[i]   = {w_p.q[i][C_W-2:0], 1'b1};
                end else begin
                    n_d.q[i]   = {w_p.q[i][C_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d1[j] <= n_d;
            end
        end
    end

    // place the root and the three quotients by branch, then square
    t_as n_as;
    always_comb begin
        t_d1 d;
        d    = r_d1[C_W-1];
        n_as = '0;
        case (d.sel)
            BR_TRACE: begin
                n_as.c  = {C_W'(d.r), d.q[2], d.q[1], d.q[0]};
                n_as.cs = {1'b0, d.ns[2], d.ns[1], d.ns[0]};
            end
            BR_X: begin
                n_as.c  = {d.q[2], d.q[1], d.q[0], C_W'(d.r)};
                n_as.cs = {d.ns[2], d.ns[1], d.ns[0], 1'b0};
            end
            BR_Y: begin
                n_as.c  = {d.q[2], d.q[1], C_W'(d.r), d.q[0]};
                n_as.cs = {d.ns[2], d.ns[1], 1'b0, d.ns[0]};
            end
            BR_Z: begin
                n_as.c  = {d.q[2], C_W'(d.r), d.q[1], d.q[0]};
                n_as.cs = {d.ns[2], 1'b0, d.ns[1], d.ns[0]};
            end
            default: begin
                n_as.c  = '0;
                n_as.cs = '0;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            n_as.sq[i] = n_as.c[i] * n_as.c[i];
        end
    end

    t_sm n_sm;
    always_comb begin
        n_sm.c    = r_as.c;
        n_sm.cs   = r_as.cs;
        n_sm.len2 = L2_W'(r_as.sq[0]) + L2_W'(r_as.sq[1])
                  + L2_W'(r_as.sq[2]) + L2_W'(r_as.sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_as <= n_as;
            r_sm <= n_sm;
        end
    end

    // length root
    t_s2 w_s2_in;
    always_comb begin
        w_s2_in      = '0;
        w_s2_in.len2 = r_sm.len2;
        w_s2_in.c    = r_sm.c;
        w_s2_in.cs   = r_sm.cs;
    end

    for (genvar j = 0; j < L_W; j++) begin : g_s2
        t_s2 w_p;
        t_s2 n_s;
        if (j == 0) begin : g_first
            assign w_p = w_s2_in;
        end else begin : g_next
            assign w_p = r_s2[j-1];
        end
        always_comb begin
            logic [L_W+3:0] sh;
            logic [L_W+3:0] tr;
            n_s = w_p;
            sh  = {w_p.rem, w_p.len2[2*(L_W-1-j)+1 -: 2]};
            tr  = {2'b00, w_p.root, 2'b01};
            if (sh >= tr) begin
                n_s.rem  = (L_W+2)'(sh - tr);
                n_s.root = {w_p.root[L_W-2:0], 1'b1};
            end else begin
                n_s.rem  = sh[L_W+1:0];
                n_s.root = {w_p.root[L_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s2[j] <= n_s;
            end
        end
    end

    // normalize: (|c| * 2^14 + len/2) / len; |c| <= len keeps it within 15 bits
    t_d2 w_d2_in;
    always_comb begin
        t_s2 s;
        s             = r_s2[L_W-1];
        w_d2_in       = '0;
        w_d2_in.len   = s.root;
        w_d2_in.cs    = s.cs;
        for (int i = 0; i < 4; i++) begin
            w_d2_in.rem[i] = {1'b0, s.c[i], {NRM_SH{1'b0}}}
                           + DV2_W'(s.root[L_W-1:1]);
        end
    end

    for (genvar j = 0; j < QN_W; j++) begin : g_d2
        t_d2 w_p;
        t_d2 n_d;
        if (j == 0) begin : g_first
            assign w_p = w_d2_in;
        end else begin : g_next
            assign w_p = r_d2[j-1];
        end
        always_comb begin
            logic [DV2_W:0] dsh;
            n_d = w_p;
            dsh = (DV2_W+1)'(w_p.len) << (QN_W - 1 - j);
            for (int i = 0; i < 4; i++) begin
                if ({1'b0, w_p.rem[i]} >= dsh) begin
                    n_d.rem[i] = DV2_W'({1'b0, w_p.rem[i]} - dsh);
                    n_d.q[i]   = {w_p.q[i][QN_W-2:0], 1'b1};
                end else begin
                    n_d.q[i]   = {w_p.q[i][QN_W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d2[j] <= n_d;
            end
        end
    end

    t_out_item n_out;
    always_comb begin
        t_d2 d;
        logic signed [Q_W-1:0] v [4];
        d = r_d2[QN_W-1];
        for (int i = 0; i < 4; i++) begin
            v[i] = d.cs[i] ? -$signed({1'b0, d.q[i]}) : $signed({1'b0, d.q[i]});
        end
        if (d.len == '0) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.quat_x     = v[0];
            n_out.quat_y     = v[1];
            n_out.quat_z     = v[2];
            n_out.quat_w     = v[3];
            n_out.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion_core.sv -----
// Top level of the rotation-matrix-to-quaternion core (Shepperd's method).
// Instantiates rmq_front, rmq_queue and rmq_back; types from rmq_pkg.
//
//   channel  | ports                         | beat accepted when
//   ---------+-------------------------------+----------------------
//   matrix   | i_push, o_full, i_item        | i_push && !o_full
//   quat     | o_empty, i_pop, o_item        | i_pop && !o_empty
//
// One beat in and one beat out per cycle sustained while every result is popped.
// An accepted matrix passes the front register, then the queue, then 93 back
// stages (24 root, 25 divide, square, sum, 26 root, 15 divide, output). The
// back pipe advances whenever its output is free or popped; the queue absorbs
// front beats during a stall.
// Reset clears all valid state.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    logic w_fv;
    t_cls w_fcls;
    logic w_q_full;
    logic w_q_empty;
    t_cls w_q_data;
    logic w_bv;
    logic w_en;

    assign w_en    = !w_bv || i_pop;
    assign o_empty = !w_bv;

    rmq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_valid  (w_fv),
        .o_cls    (w_fcls),
        .i_q_full (w_q_full)
    );

    rmq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fv),
        .i_data  (w_fcls),
        .o_full  (w_q_full),
        .i_pop   (w_en),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    rmq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!w_q_empty),
        .i_cls   (w_q_data),
        .o_valid (w_bv),
        .o_item  (o_item)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_empty)
        else $error("result visible right after reset");

    a_no_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !o_item.degenerate)
        else $error("zero length result from a nonzero root");

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("queue full and empty at once");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> w_fv && w_q_full)
        else $error("front stalls with room downstream");

endmodule

// ----- verif/rmq_checker.sv -----
// Checker for rotation_matrix_to_quaternion_core: watches both queue ports,
// predicts each quaternion beat and compares it field by field. Uses rmq_pkg.
module rmq_checker
    import rmq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_item,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_item i_quat,
    output int        o_errors,
    output int        o_pending,
    output int        o_beats_out,
    output int        o_branch_hits [4]
);

    t_out_item quat_exp_q[$];
    int        mismatch_cnt;

    function automatic longint unsigned isqrt64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // n * 2^30 / r, truncated toward zero
    function automatic longint scale_offdiag(longint n, longint unsigned r);
        longint unsigned q;
        if (r == 0) return 0;
        q = (absv(n) << 30) / r;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [Q_W-1:0] norm_q14(longint c, longint unsigned len);
        longint unsigned q;
        longint v;
        q = ((absv(c) << 14) + (len >> 1)) / len;
        if (q > 32768) q = 32768;
        v = c < 0 ? -longint'(q) : longint'(q);
        if (v > 32767) v = 32767;
        return v[Q_W-1:0];
    endfunction

    function automatic t_out_item predict_quat(t_in_item m, output t_branch br);
        longint m00, m10, m20, m01, m11, m21, m02, m12, m22, dsum, t;
        longint qx, qy, qz, qw;
        longint unsigned r, len;
        t_out_item o;
        m00 = m.right_x; m10 = m.right_y; m20 = m.right_z;
        m01 = m.up_x;    m11 = m.up_y;    m21 = m.up_z;
        m02 = m.fwd_x;   m12 = m.fwd_y;   m22 = m.fwd_z;
        dsum = m00 + m11 + m22;
        if (dsum > 0) begin
            br = BR_TRACE;
            t = ONE_Q14 + dsum;
        end else if (m00 > m11 && m00 > m22) begin
            br = BR_X;
            t = ONE_Q14 + m00 - m11 - m22;
        end else if (m11 > m22) begin
            br = BR_Y;
            t = ONE_Q14 + m11 - m00 - m22;
        end else begin
            br = BR_Z;
            t = ONE_Q14 + m22 - m00 - m11;
        end
        r = isqrt64((t > 0 ? longint'(t) : 0) << 30);
        case (br)
            BR_TRACE: begin
                qx = scale_offdiag(m21 - m12, r);
                qy = scale_offdiag(m02 - m20, r);
                qz = scale_offdiag(m10 - m01, r);
                qw = r;
            end
            BR_X: begin
                qx = r;
                qy = scale_offdiag(m01 + m10, r);
                qz = scale_offdiag(m02 + m20, r);
                qw = scale_offdiag(m21 - m12, r);
            end
            BR_Y: begin
                qx = scale_offdiag(m10 + m01, r);
                qy = r;
                qz = scale_offdiag(m12 + m21, r);
                qw = scale_offdiag(m02 - m20, r);
            end
            default: begin
                qx = scale_offdiag(m02 + m20, r);
                qy = scale_offdiag(m12 + m21, r);
                qz = r;
                qw = scale_offdiag(m10 - m01, r);
            end
        endcase
        len = isqrt64(absv(qx) * absv(qx) + absv(qy) * absv(qy)
                    + absv(qz) * absv(qz) + absv(qw) * absv(qw));
        o = '0;
        if (len == 0) begin
            o.degenerate = 1'b1;
        end else begin
            o.quat_x = norm_q14(qx, len);
            o.quat_y = norm_q14(qy, len);
            o.quat_z = norm_q14(qz, len);
            o.quat_w = norm_q14(qw, len);
        end
        return o;
    endfunction

    assign o_errors = mismatch_cnt;

    always @(posedge i_clk) begin
        t_out_item exp_q;
        t_branch   br;
        if (!i_rst_n) begin
            quat_exp_q.delete();
            mismatch_cnt = 0;
            o_pending = 0;
            o_beats_out = 0;
            for (int i = 0; i < 4; i++) o_branch_hits[i] = 0;
        end else begin
            if (i_push && !i_full) begin
                quat_exp_q.push_back(predict_quat(i_item, br));
                o_branch_hits[br]++;
            end
            if (i_pop && !i_empty) begin
                o_beats_out++;
                if (quat_exp_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: unexpected quat beat %h", i_quat);
                end else begin
                    exp_q = quat_exp_q.pop_front();
                    if (exp_q.quat_x !== i_quat.quat_x || exp_q.quat_y !== i_quat.quat_y ||
                        exp_q.quat_z !== i_quat.quat_z || exp_q.quat_w !== i_quat.quat_w ||
                        exp_q.degenerate !== i_quat.degenerate) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("ERROR: quat mismatch exp x=%0d y=%0d z=%0d w=%0d d=%b",
                                     exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                                     exp_q.quat_w, exp_q.degenerate,
                                     " got x=%0d y=%0d z=%0d w=%0d d=%b",
                                     i_quat.quat_x, i_quat.quat_y, i_quat.quat_z,
                                     i_quat.quat_w, i_quat.degenerate);
                    end
                end
            end
            o_pending = quat_exp_q.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for rotation_matrix_to_quaternion_core: drives matrix beats
// and pops quaternions with random gaps; checking lives in rmq_checker.
module tb;
    import rmq_pkg::*;

    localparam int LATENCY   = 94;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      i_pop;
    t_in_item  i_item;
    logic      o_full;
    logic      o_empty;
    t_out_item o_item;
    int        errors;
    int        pending;
    int        beats_out;
    int        branch_hits [4];
    int        cycle_cnt = 0;
    int        items_sent;

    rotation_matrix_to_quaternion_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_item)
    );

    rmq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_full        (o_full),
        .i_item        (i_item),
        .i_empty       (o_empty),
        .i_pop         (i_pop),
        .i_quat        (o_item),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_beats_out   (beats_out),
        .o_branch_hits (branch_hits)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLE) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern: some stretches always ready, some choppy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (cycle_cnt % 3000 < 600) begin
            i_pop <= 1'b1;
        end else if (cycle_cnt % 3000 < 1800) begin
            i_pop <= ($urandom_range(0, 3) != 0);
        end else begin
            i_pop <= ($urandom_range(0, 3) == 0);
        end
    end

    function automatic logic [Q_W-1:0] rand_q14(int mode);
        case (mode)
            0: return Q_W'($urandom);
            1: return Q_W'($urandom_range(0, 32768) - 16384);
            default: return Q_W'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    // random entries; for some kinds, one cyclic axis permutation with signs plus small noise
    function automatic t_in_item rand_matrix();
        t_in_item m;
        int mode;
        int kind;
        logic [Q_W-1:0] e [9];
        kind = $urandom_range(0, 9);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 9; i++) e[i] = rand_q14(kind < 3 ? 0 : mode);
        if (kind >= 6) begin
            int p;
            p = $urandom_range(0, 2);
            for (int c = 0; c < 3; c++) begin
                int rr;
                rr = (c + p) % 3;
                e[c*3 + rr] = Q_W'(($urandom_range(0, 1) ? 16384 : -16384)
                                   + $urandom_range(0, 600) - 300);
            end
        end
        m.right_x = e[0]; m.right_y = e[1]; m.right_z = e[2];
        m.up_x    = e[3]; m.up_y    = e[4]; m.up_z    = e[5];
        m.fwd_x   = e[6]; m.fwd_y   = e[7]; m.fwd_z   = e[8];
        return m;
    endfunction

    task automatic send_matrix(t_in_item m);
        i_item <= m;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    task automatic pause_sender(int n);
        i_push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(int a, int b, int c, int d, int e, int f,
                                    int g, int h, int k);
        t_in_item m;
        m.right_x = Q_W'(a); m.right_y = Q_W'(b); m.right_z = Q_W'(c);
        m.up_x    = Q_W'(d); m.up_y    = Q_W'(e); m.up_z    = Q_W'(f);
        m.fwd_x   = Q_W'(g); m.fwd_y   = Q_W'(h); m.fwd_z   = Q_W'(k);
        return m;
    endfunction

    initial begin
        t_in_item directed [$];
        int burst;
        int wait_cnt;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_item = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));      // identity
        directed.push_back(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));    // x branch
        directed.push_back(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));    // y branch
        directed.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));    // z branch
        directed.push_back(mk(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));     // 90 deg about z
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                  // zero trace, ties
        directed.push_back(mk(-5, 0, 0, 0, -5, 0, 0, 0, -5));               // all diag equal
        directed.push_back(mk(100, 0, 0, 0, 100, 0, 0, 0, -300));           // tie m00 == m11
        directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        directed.push_back(mk(-32768, 32767, -32768, -32768, -32768, 32767,
                              32767, -32768, -32768));                      // saturation
        directed.push_back(mk(32767, -32768, 32767, 32767, -32768, -32768,
                              -32768, 32767, -32768));
        directed.push_back(mk(-32768, 32767, 32767, 32767, -32768, 32767,
                              32767, 32767, 32767));
        directed.push_back(mk(1, -1, 1, -1, 0, -1, 1, -1, -1));             // tiny
        directed.push_back(mk(-1, 16'h5555, 16'haaaa, 16'h5555, -1, 16'haaaa,
                              16'haaaa, 16'h5555, 2));
        directed.push_back(mk(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'h5555,
                              16'h5555, 16'haaaa, 16'haaaa, 16'haaaa));
        foreach (directed[i]) send_matrix(directed[i]);

        // hold off until everything has drained
        i_push <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        while (items_sent < directed.size() + N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++) send_matrix(rand_matrix());
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        i_push <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d matrices, checked %0d quaternions", items_sent, beats_out);
        $display("Branches: trace %0d, x %0d, y %0d, z %0d",
                 branch_hits[BR_TRACE], branch_hits[BR_X], branch_hits[BR_Y],
                 branch_hits[BR_Z]);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
